/* hdl/gbn_pkg.sv */
package gbn_pkg;

   localparam int SEQ_BITS    = 16;
   localparam int TIMER_BITS  = 16;
   localparam int WIN_BITS    = 6;
   localparam int DUP_BITS    = 3;
   localparam int WINDOW_MAX  = 32;
   localparam int MAX_RESULTS = 32;
   localparam int DUP_TRIGGER = 3;
   localparam int DUP_MAX     = 7;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int WINDOW_CAP  = (WINDOW_MAX < MAX_RESULTS) ? WINDOW_MAX : MAX_RESULTS;

   localparam logic [WIN_BITS-1:0]   WINDOW_SIZE_RESET   = WIN_BITS'(20);
   localparam logic [TIMER_BITS-1:0] TIMEOUT_TICKS_RESET = TIMER_BITS'(5000);
   localparam logic [SEQ_BITS-1:0]   FIRST_SEQ_RESET     = SEQ_BITS'(2);
   localparam logic [SEQ_BITS-1:0]   LAST_SEQ_RESET      = SEQ_BITS'(65535);

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_SEND    = 2'd1,
      MODE_ACK     = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_SEND     = 3'd1,
      KIND_REFUSED  = 3'd2,
      KIND_RETX     = 3'd3,
      KIND_FINISHED = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      REG_WINDOW_SIZE   = 2'd0,
      REG_TIMEOUT_TICKS = 2'd1,
      REG_FIRST_SEQ     = 2'd2,
      REG_LAST_SEQ      = 2'd3
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic multi;
      logic run_last;
   } status_type;

endpackage

/* hdl/gbn_ctrl.sv */
module gbn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  gbn_pkg::status_type  status,
   output gbn_pkg::cmd_type     cmd
);
   import gbn_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free && !reset;
            cmd.accept = req_tvalid && req_tready;
            if (cmd.accept && status.multi) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.run_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/gbn_datapath.sv */
module gbn_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gbn_pkg::cmd_type     cmd,
   output gbn_pkg::status_type  status,
   input  logic [1:0]           req_mode,
   input  logic [15:0]          req_ack_number,
   input  logic                 req_ack_valid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [15:0]          rsp_seq,
   output logic [5:0]           rsp_in_flight,
   output logic                 rsp_last
);
   import gbn_pkg::*;

   logic [WIN_BITS-1:0]   window_size_ff;
   logic [TIMER_BITS-1:0] timeout_ff;
   logic [SEQ_BITS-1:0]   first_seq_ff;
   logic [SEQ_BITS-1:0]   last_seq_ff;

   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS-1:0]   next_ff, next_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [SEQ_BITS-1:0]   dup_num_ff, dup_num_in;
   logic                  dup_seen_ff, dup_seen_in;
   logic [DUP_BITS-1:0]   dup_cnt_ff, dup_cnt_in;
   logic                  fin_ff, fin_in;
   logic [CNT_BITS-1:0]   run_idx_ff, run_idx_in;
   logic [CNT_BITS-1:0]   run_cnt_ff, run_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [SEQ_BITS-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [WIN_BITS-1:0]   rsp_flight_ff, rsp_flight_in;
   logic                  rsp_last_ff, rsp_last_in;

   mode_type              mode;
   logic [SEQ_BITS-1:0]   flight;
   logic [SEQ_BITS-1:0]   new_flight;
   logic [SEQ_BITS:0]     top;
   logic [SEQ_BITS:0]     ack_cap;
   logic [SEQ_BITS:0]     ack_wide;
   logic [SEQ_BITS-1:0]   ack_eff;
   logic [TIMER_BITS:0]   timer_inc;
   logic [WIN_BITS-1:0]   eff_win;
   logic                  ev_run;
   logic                  ev_retx;
   kind_type              ev_kind;
   logic [SEQ_BITS-1:0]   ev_seq;
   logic [CNT_BITS-1:0]   run_n;

   assign mode      = mode_type'(req_mode);
   assign csr_ready = !reset;

   always_comb begin
      flight      = next_ff - base_ff;
      top         = {1'b0, base_ff} + {1'b0, flight};
      ack_cap     = top - 1'b1;
      ack_wide    = ({1'b0, req_ack_number} > ack_cap) ? ack_cap : {1'b0, req_ack_number};
      ack_eff     = ack_wide[SEQ_BITS-1:0];
      timer_inc   = {1'b0, timer_ff} + 1'b1;
      eff_win     = (window_size_ff > WIN_BITS'(WINDOW_CAP)) ? WIN_BITS'(WINDOW_CAP)
                                                             : window_size_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      timer_in    = timer_ff;
      dup_num_in  = dup_num_ff;
      dup_seen_in = dup_seen_ff;
      dup_cnt_in  = dup_cnt_ff;
      fin_in      = fin_ff;
      ev_run      = 1'b0;
      ev_kind     = KIND_NONE;
      ev_seq      = '0;
      case (mode)
         MODE_TICK: begin
            if (!fin_ff) begin
               if (timer_inc > {1'b0, timeout_ff}) begin
                  timer_in = '0;
                  ev_run   = 1'b1;
               end else begin
                  timer_in = timer_inc[TIMER_BITS-1:0];
               end
            end
         end
         MODE_SEND: begin
            if (!fin_ff && (flight < SEQ_BITS'(eff_win)) && (top <= {1'b0, last_seq_ff})) begin
               ev_kind = KIND_SEND;
               ev_seq  = next_ff;
               next_in = next_ff + 1'b1;
               if (flight == '0) begin
                  timer_in = '0;
               end
            end else begin
               ev_kind = KIND_REFUSED;
            end
         end
         MODE_ACK: begin
            if (req_ack_valid && !fin_ff && (top != '0)) begin
               if (ack_eff >= base_ff) begin
                  base_in = ack_eff + 1'b1;
               end
               if ((next_ff - base_in) != '0) begin
                  timer_in = '0;
               end
               if (ack_eff == last_seq_ff) begin
                  fin_in  = 1'b1;
                  ev_kind = KIND_FINISHED;
               end else if (dup_seen_ff && (dup_num_ff == ack_eff)) begin
                  if (dup_cnt_ff < DUP_BITS'(DUP_MAX)) begin
                     dup_cnt_in = dup_cnt_ff + 1'b1;
                     if (dup_cnt_in == DUP_BITS'(DUP_TRIGGER)) begin
                        ev_run   = 1'b1;
                        timer_in = '0;
                     end
                  end
               end else begin
                  dup_seen_in = 1'b1;
                  dup_num_in  = ack_eff;
                  dup_cnt_in  = '0;
               end
            end
         end
         default: begin
            base_in     = first_seq_ff;
            next_in     = first_seq_ff;
            timer_in    = '0;
            dup_num_in  = '0;
            dup_seen_in = 1'b0;
            dup_cnt_in  = '0;
            fin_in      = 1'b0;
         end
      endcase
      new_flight = next_in - base_in;
      run_n      = (new_flight > SEQ_BITS'(MAX_RESULTS)) ? CNT_BITS'(MAX_RESULTS)
                                                         : new_flight[CNT_BITS-1:0];
      ev_retx    = ev_run && (run_n != '0);
      if (ev_retx) begin
         ev_kind = KIND_RETX;
         ev_seq  = base_in;
      end
   end

   always_comb begin
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.multi    = ev_retx && (run_n > CNT_BITS'(1));
      status.run_last = (run_idx_ff == (run_cnt_ff - 1'b1));
   end

   always_comb begin
      run_idx_in    = run_idx_ff;
      run_cnt_in    = run_cnt_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_flight_in = rsp_flight_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (cmd.accept) begin
         run_idx_in    = CNT_BITS'(1);
         run_cnt_in    = run_n;
         rsp_kind_in   = ev_kind;
         rsp_seq_in    = ev_seq;
         rsp_flight_in = new_flight[WIN_BITS-1:0];
         rsp_last_in   = !status.multi;
         rsp_valid_in  = 1'b1;
      end else if (cmd.emit) begin
         run_idx_in    = run_idx_ff + 1'b1;
         rsp_kind_in   = KIND_RETX;
         rsp_seq_in    = base_ff + SEQ_BITS'(run_idx_ff);
         rsp_flight_in = flight[WIN_BITS-1:0];
         rsp_last_in   = status.run_last;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         timeout_ff     <= TIMEOUT_TICKS_RESET;
         first_seq_ff   <= FIRST_SEQ_RESET;
         last_seq_ff    <= LAST_SEQ_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_WINDOW_SIZE:   window_size_ff <= csr_data[WIN_BITS-1:0];
            REG_TIMEOUT_TICKS: timeout_ff     <= csr_data[TIMER_BITS-1:0];
            REG_FIRST_SEQ:     first_seq_ff   <= csr_data[SEQ_BITS-1:0];
            REG_LAST_SEQ:      last_seq_ff    <= csr_data[SEQ_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         timer_ff     <= '0;
         dup_num_ff   <= '0;
         dup_seen_ff  <= 1'b0;
         dup_cnt_ff   <= '0;
         fin_ff       <= 1'b0;
         run_idx_ff   <= '0;
         run_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            base_ff     <= base_in;
            next_ff     <= next_in;
            timer_ff    <= timer_in;
            dup_num_ff  <= dup_num_in;
            dup_seen_ff <= dup_seen_in;
            dup_cnt_ff  <= dup_cnt_in;
            fin_ff      <= fin_in;
         end
         run_idx_ff   <= run_idx_in;
         run_cnt_ff   <= run_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_flight_ff <= rsp_flight_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_seq       = rsp_seq_ff;
   assign rsp_in_flight = rsp_flight_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* hdl/go_back_n_send_window.sv */
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  tdata ack_number, tuser mode and ack_valid
// rsp      out        rsp_tvalid / rsp_tready  tdata seq and in_flight, tuser kind, tlast
// csr      in         csr_valid / csr_ready    csr_index, csr_data
//
// Each input transaction is decided combinationally and its first result is registered.
// A retransmit run of n results holds the input off while the run counter steps through
// the window, one result per cycle when the output drains.
// The single output register lets a new input be taken in the cycle its result leaves.
// Reset restores the register defaults and clears the window state; req and csr are not
// ready while reset is high, and csr is always ready otherwise.
module go_back_n_send_window (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ack_number [15:0]
   input  logic [2:0]  req_tuser,   // mode [1:0], ack_valid [2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // seq [15:0], in_flight [21:16], zero [23:22]
   output logic [2:0]  rsp_tuser,   // kind [2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import gbn_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [15:0] rsp_seq;
   logic [5:0]  rsp_in_flight;

   gbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gbn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_tuser[1:0]),
      .req_ack_number (req_tdata),
      .req_ack_valid  (req_tuser[2]),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_kind       (rsp_tuser),
      .rsp_seq        (rsp_seq),
      .rsp_in_flight  (rsp_in_flight),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_in_flight, rsp_seq};

endmodule
